@@ design/tdcd_pkg.sv @@
// ----------------------------------------------------------------------------
// tdcd_pkg: shared types and constants for the two-digit counter display
// Register indexes, reset values, button direction codes and the
// active-low seven-segment decode.
// ----------------------------------------------------------------------------
package tdcd_pkg;

   localparam int unsigned REG_W     = 8;
   localparam int unsigned COUNT_W   = 7;
   localparam int unsigned CSR_ADDR_W = 2;

   localparam logic [COUNT_W-1:0] COUNT_MAX = 7'd99;

   // Register reset values
   localparam logic [REG_W-1:0] RESET_INITIAL_REPEAT   = 8'd50;
   localparam logic [REG_W-1:0] RESET_REPEAT_DECREMENT = 8'd5;
   localparam logic [REG_W-1:0] RESET_MIN_REPEAT       = 8'd15;

   // Register indexes
   localparam logic [CSR_ADDR_W-1:0] REG_INITIAL_REPEAT   = 2'd0;
   localparam logic [CSR_ADDR_W-1:0] REG_REPEAT_DECREMENT = 2'd1;
   localparam logic [CSR_ADDR_W-1:0] REG_MIN_REPEAT       = 2'd2;

   // Held button; code 3 is treated as no button held
   typedef enum logic [1:0] {
      DIR_NONE = 2'd0,
      DIR_UP   = 2'd1,
      DIR_DOWN = 2'd2
   } dir_type;

   // Active-low common-anode pattern, dot bit off
   function automatic logic [7:0] seg_decode(input logic [3:0] digit);
      logic [7:0] seg;
      unique case (digit)
         4'd0:    seg = 8'd192;
         4'd1:    seg = 8'd249;
         4'd2:    seg = 8'd164;
         4'd3:    seg = 8'd176;
         4'd4:    seg = 8'd153;
         4'd5:    seg = 8'd146;
         4'd6:    seg = 8'd130;
         4'd7:    seg = 8'd248;
         4'd8:    seg = 8'd128;
         4'd9:    seg = 8'd152;
         default: seg = 8'd255;
      endcase
      return seg;
   endfunction

endpackage

@@ design/two_digit_updown_counter_display_core.sv @@
// ----------------------------------------------------------------------------
// two_digit_updown_counter_display_core
// Decimal 0..99 up/down counter with multiplexed seven-segment output and
// accelerating button auto-repeat.
// ----------------------------------------------------------------------------
// Each request transaction is one display slot tick carrying the button
// levels; each tick yields exactly one response transaction. The counter
// state and the response register update in the cycle the tick is
// accepted, and a new tick is taken every cycle as long as the response
// register is empty or being drained in the same cycle.
// Slots alternate units (digit_select 0) and tens (digit_select 1); buttons
// are sampled on the tens slot, up before down. A held button steps the
// count whenever its progress reaches the repeat interval, which then
// shrinks by repeat_decrement down to min_repeat; release gives one more
// step and restores initial_repeat. The count wraps both ways. Register
// writes on the csr port take effect at the next sample and leave the
// running interval alone.
module two_digit_updown_counter_display_core
   import tdcd_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   // Request: [0] up_pressed, [1] down_pressed, [7:2] zero
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [7:0]            req_tdata,
   // Response: [7:0] segments, [14:8] count_value, [15] zero
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [15:0]           rsp_tdata,
   // Response: [0] digit_select
   output logic                  rsp_tuser,
   // Configuration write port
   input  logic                  csr_we,
   input  logic [CSR_ADDR_W-1:0] csr_addr,
   input  logic [REG_W-1:0]      csr_wdata
);

   // Configuration registers
   logic [REG_W-1:0] init_ff, dec_ff, min_ff;

   // Counter state
   logic               phase_ff, phase_in;
   logic [COUNT_W-1:0] count_ff, count_in;
   logic [REG_W-1:0]   interval_ff, interval_in;
   logic [REG_W-1:0]   progress_ff, progress_in;
   dir_type            held_ff, held_in;

   // Response register
   logic               rsp_valid_ff;
   logic [7:0]         seg_ff, seg_in;
   logic [COUNT_W-1:0] rsp_count_ff;
   logic               rsp_sel_ff;

   logic               req_accept;
   logic               up, down;
   logic [COUNT_W-1:0] count_clamped;
   logic [14:0]        tens_prod;
   logic [3:0]         tens, units, digit;
   logic [COUNT_W-1:0] tens_times_ten;
   logic               still, do_step;
   dir_type            step_dir;
   logic [REG_W-1:0]   progress_inc, interval_sub, interval_floor;
   logic [COUNT_W-1:0] count_up, count_down;

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign req_accept = req_tvalid && req_tready;
   assign up         = req_tdata[0];
   assign down       = req_tdata[1];

   // Split the count into tens and units: x*205>>11 is x/10 for x below 1029
   assign count_clamped  = (count_ff > COUNT_MAX) ? '0 : count_ff;
   assign tens_prod      = {8'd0, count_clamped} * 15'd205;
   assign tens           = tens_prod[14:11];
   assign tens_times_ten = {tens, 3'b000} + {2'b00, tens, 1'b0};
   assign units          = 4'(count_clamped - tens_times_ten);
   assign digit          = phase_ff ? tens : units;
   assign seg_in         = seg_decode(digit);

   // Wrapping step values
   assign count_up   = (count_ff >= COUNT_MAX) ? '0 : count_ff + 7'd1;
   assign count_down = (count_ff == '0 || count_ff > COUNT_MAX) ? COUNT_MAX
                                                                : count_ff - 7'd1;

   // Saturating progress and shrunk interval with floor
   assign progress_inc   = (progress_ff == 8'hFF) ? progress_ff : progress_ff + 8'd1;
   assign interval_sub   = (interval_ff > dec_ff) ? interval_ff - dec_ff : '0;
   assign interval_floor = (interval_sub < min_ff) ? min_ff : interval_sub;

   // Sample buttons at the end of the display cycle
   always_comb begin
      phase_in    = !phase_ff;
      count_in    = count_ff;
      interval_in = interval_ff;
      progress_in = progress_ff;
      held_in     = held_ff;
      do_step     = 1'b0;
      step_dir    = held_ff;
      still       = 1'b0;
      if (phase_ff) begin
         unique case (held_ff)
            DIR_UP:   still = up;
            DIR_DOWN: still = down;
            default:  still = 1'b0;
         endcase
         if (held_ff != DIR_UP && held_ff != DIR_DOWN) begin
            // Arm on a new press, no step
            held_in     = up ? DIR_UP : (down ? DIR_DOWN : DIR_NONE);
            progress_in = '0;
         end else if (still) begin
            // Advance auto-repeat
            progress_in = progress_inc;
            if (progress_inc >= interval_ff) begin
               interval_in = interval_floor;
               progress_in = '0;
               do_step     = 1'b1;
            end
         end else begin
            // Release: one step, restore interval, re-detect
            do_step     = 1'b1;
            interval_in = init_ff;
            held_in     = up ? DIR_UP : (down ? DIR_DOWN : DIR_NONE);
            progress_in = '0;
         end
         if (do_step) begin
            count_in = (step_dir == DIR_UP) ? count_up : count_down;
         end
      end
   end

   // Hold state, configuration and the response register
   always_ff @(posedge clock) begin
      if (reset) begin
         init_ff      <= RESET_INITIAL_REPEAT;
         dec_ff       <= RESET_REPEAT_DECREMENT;
         min_ff       <= RESET_MIN_REPEAT;
         phase_ff     <= 1'b0;
         count_ff     <= '0;
         interval_ff  <= RESET_INITIAL_REPEAT;
         progress_ff  <= '0;
         held_ff      <= DIR_NONE;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_we) begin
            unique case (csr_addr)
               REG_INITIAL_REPEAT:   init_ff <= csr_wdata;
               REG_REPEAT_DECREMENT: dec_ff  <= csr_wdata;
               REG_MIN_REPEAT:       min_ff  <= csr_wdata;
               default: ;
            endcase
         end
         if (req_accept) begin
            phase_ff     <= phase_in;
            count_ff     <= count_in;
            interval_ff  <= interval_in;
            progress_ff  <= progress_in;
            held_ff      <= held_in;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Response payload needs no reset
   always_ff @(posedge clock) begin
      if (req_accept) begin
         seg_ff       <= seg_in;
         rsp_count_ff <= count_in;
         rsp_sel_ff   <= phase_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {1'b0, rsp_count_ff, seg_ff};
   assign rsp_tuser  = rsp_sel_ff;

   // Count stays in decimal range
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= COUNT_MAX)
      else $error("count left 0..99");

   // Units slot never changes the count
   a_units_hold: assert property (@(posedge clock) disable iff (reset)
      (req_accept && !phase_ff) |=> (count_ff == $past(count_ff)))
      else $error("count changed on units slot");

   // Slot phase toggles on every tick
   a_phase_toggle: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> (phase_ff != $past(phase_ff)))
      else $error("slot phase did not toggle");

   // Response shows the slot that was driven and the new count
   a_rsp_match: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> (rsp_tuser == $past(phase_ff) && rsp_tdata[14:8] == count_ff))
      else $error("response does not match tick");

endmodule
